// ----- sv/fmr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types and constants of the framed message receiver.
// ----------------------------------------------------------------------------
package fmr_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;
  localparam int unsigned POS_W             = 7;
  localparam int unsigned CNT_W             = 7;
  localparam int unsigned IDX_W             = 6;
  localparam int unsigned CFG_W             = 64;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned OUT_DEPTH         = 4;
  localparam int unsigned OUT_PTR_W         = 2;
  localparam int unsigned OUT_CNT_W         = 3;

  // Header positions of the parser.
  localparam logic [POS_W-1:0] POS_START  = 7'd0;
  localparam logic [POS_W-1:0] POS_TEXT   = 7'd1;
  localparam logic [POS_W-1:0] POS_DEST   = 7'd2;
  localparam logic [POS_W-1:0] POS_SOURCE = 7'd3;
  localparam logic [POS_W-1:0] POS_LEN    = 7'd4;
  localparam logic [POS_W-1:0] POS_ID     = 7'd5;

  localparam logic [7:0] HEADER_LEN    = 8'd6;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd7;

  localparam logic [7:0]       START_RST  = 8'd16;
  localparam logic [7:0]       TEXT_RST   = 8'd2;
  localparam logic [7:0]       DEST_RST   = 8'd136;
  localparam logic [7:0]       SOURCE_RST = 8'd0;
  localparam logic [CFG_W-1:0] MASK_RST   = 64'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START  = 3'd0,
    REG_TEXT   = 3'd1,
    REG_DEST   = 3'd2,
    REG_SOURCE = 3'd3,
    REG_MASK0  = 3'd4,
    REG_MASK1  = 3'd5,
    REG_MASK2  = 3'd6,
    REG_MASK3  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_CSUM_ERR = 2'd2
  } kind_e;

  // One finished frame handed from the parser to the emitter.
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       id;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       id;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/fmr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmr_front
// Frame parser: header match, id filter, payload capture and checksum check.
// ----------------------------------------------------------------------------
module fmr_front #(
  parameter int unsigned PAYLOAD_DEPTH = fmr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fmr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fmr_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          accept_i,
  input  wire logic                          cmd_i,
  input  wire logic [7:0]                    rx_byte_i,
  output fmr_pkg::job_t                      job_o,
  output logic                               job_push_o,
  output fmr_pkg::store_wr_t                 st_wr_o
);

  logic [7:0]               start_q, text_q, dest_q, source_q;
  logic [fmr_pkg::CFG_W-1:0] mask_q [4];

  logic [fmr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                len_q, len_d;
  logic [7:0]                id_q, id_d;
  logic [7:0]                sum_q, sum_d;
  logic                      held_q, held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= fmr_pkg::START_RST;
      text_q   <= fmr_pkg::TEXT_RST;
      dest_q   <= fmr_pkg::DEST_RST;
      source_q <= fmr_pkg::SOURCE_RST;
      mask_q   <= '{default: fmr_pkg::MASK_RST};
    end else if (cfg_we_i) begin
      unique case (fmr_pkg::cfg_reg_e'(cfg_idx_i))
        fmr_pkg::REG_START:  start_q   <= cfg_data_i[7:0];
        fmr_pkg::REG_TEXT:   text_q    <= cfg_data_i[7:0];
        fmr_pkg::REG_DEST:   dest_q    <= cfg_data_i[7:0];
        fmr_pkg::REG_SOURCE: source_q  <= cfg_data_i[7:0];
        fmr_pkg::REG_MASK0:  mask_q[0] <= cfg_data_i;
        fmr_pkg::REG_MASK1:  mask_q[1] <= cfg_data_i;
        fmr_pkg::REG_MASK2:  mask_q[2] <= cfg_data_i;
        fmr_pkg::REG_MASK3:  mask_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      id_q   <= '0;
      sum_q  <= '0;
      held_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      id_q   <= id_d;
      sum_q  <= sum_d;
      held_q <= held_d;
    end
  end

  always_comb begin
    logic [fmr_pkg::POS_W-1:0] idx;
    logic [7:0]                count;
    logic                      id_ok;

    pos_d      = pos_q;
    len_d      = len_q;
    id_d       = id_q;
    sum_d      = sum_q;
    held_d     = held_q;
    job_push_o = 1'b0;
    job_o      = '{kind: fmr_pkg::KIND_EMPTY, id: id_q, count: '0};
    st_wr_o    = '{we: 1'b0, addr: '0, data: rx_byte_i};

    idx   = pos_q - fmr_pkg::POS_W'(fmr_pkg::HEADER_LEN);
    count = len_q - fmr_pkg::MIN_FRAME_LEN;
    id_ok = mask_q[id_q[7:6]][id_q[5:0]];

    if (accept_i) begin
      if (cmd_i) begin
        held_d = 1'b0;
      end else if (held_q) begin
        pos_d = fmr_pkg::POS_START;
        sum_d = '0;
      end else begin
        case (pos_q)
          fmr_pkg::POS_START: begin
            if (rx_byte_i == start_q) begin
              pos_d = fmr_pkg::POS_TEXT;
              sum_d = rx_byte_i;
            end
          end
          fmr_pkg::POS_TEXT: begin
            if (rx_byte_i == text_q) begin
              pos_d = fmr_pkg::POS_DEST;
              sum_d = sum_q + rx_byte_i;
            end
          end
          fmr_pkg::POS_DEST: begin
            if (rx_byte_i == dest_q) begin
              pos_d = fmr_pkg::POS_SOURCE;
              sum_d = sum_q + rx_byte_i;
            end
          end
          fmr_pkg::POS_SOURCE: begin
            if (rx_byte_i == source_q) begin
              pos_d = fmr_pkg::POS_LEN;
              sum_d = sum_q + rx_byte_i;
            end
          end
          fmr_pkg::POS_LEN: begin
            len_d = rx_byte_i;
            sum_d = sum_q + rx_byte_i;
            pos_d = fmr_pkg::POS_ID;
          end
          fmr_pkg::POS_ID: begin
            id_d  = rx_byte_i;
            sum_d = sum_q + rx_byte_i;
            pos_d = fmr_pkg::POS_W'(fmr_pkg::HEADER_LEN);
          end
          default: begin
            if (len_q < fmr_pkg::MIN_FRAME_LEN || !id_ok) begin
              pos_d = fmr_pkg::POS_START;
            end else if ({1'b0, idx} < count) begin
              if (idx >= fmr_pkg::POS_W'(PAYLOAD_DEPTH)) begin
                pos_d = fmr_pkg::POS_START;
              end else begin
                st_wr_o.we   = 1'b1;
                st_wr_o.addr = idx[fmr_pkg::IDX_W-1:0];
                sum_d        = sum_q + rx_byte_i;
                pos_d        = pos_q + fmr_pkg::POS_W'(1);
              end
            end else begin
              // Checksum byte: the payload count is within the store here.
              pos_d      = fmr_pkg::POS_START;
              job_push_o = 1'b1;
              job_o.count = count[fmr_pkg::CNT_W-1:0];
              if (rx_byte_i != sum_q) begin
                job_o.kind = fmr_pkg::KIND_CSUM_ERR;
              end else begin
                held_d = 1'b1;
                job_o.kind = (count == '0) ? fmr_pkg::KIND_EMPTY : fmr_pkg::KIND_PAYLOAD;
              end
            end
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/fmr_jobq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmr_jobq
// Two-entry queue of finished frames between the parser and the emitter.
// ----------------------------------------------------------------------------
module fmr_jobq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire fmr_pkg::job_t job_i,
  input  wire logic          pop_i,
  output logic               valid_o,
  output fmr_pkg::job_t      job_o,
  output logic               full_o,
  output logic               has_stream_o
);

  fmr_pkg::job_t ent_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= job_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == 2'd2);
  assign job_o   = ent_q[rd_q];

  always_comb begin
    logic live;
    has_stream_o = 1'b0;
    for (int i = 0; i < 2; i++) begin
      live = (cnt_q == 2'd2) || (cnt_q == 2'd1 && rd_q == 1'(i));
      if (live && ent_q[i].kind == fmr_pkg::KIND_PAYLOAD) begin
        has_stream_o = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/fmr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmr_back
// Emitter: holds the payload store and turns each job into result words.
// ----------------------------------------------------------------------------
module fmr_back #(
  parameter int unsigned PAYLOAD_DEPTH = fmr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fmr_pkg::store_wr_t st_wr_i,
  input  wire logic               job_valid_i,
  input  wire fmr_pkg::job_t      job_i,
  output logic                    job_pop_o,
  output logic                    busy_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output fmr_pkg::result_t        res_o
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [7:0] mem [PAYLOAD_DEPTH];

  logic                       active_q;
  fmr_pkg::job_t              job_q;
  logic [fmr_pkg::CNT_W-1:0]  ptr_q;
  logic                       s_valid_q;
  fmr_pkg::result_t           s_res_q;
  logic [7:0]                 rd_data_q;

  fmr_pkg::result_t               fifo_q [fmr_pkg::OUT_DEPTH];
  logic [fmr_pkg::OUT_PTR_W-1:0]  wr_q, rd_q;
  logic [fmr_pkg::OUT_CNT_W-1:0]  cnt_q;

  logic             space, issue, rd_last, issue_done, is_payload, out_pop;
  fmr_pkg::result_t push_res;

  assign space = (cnt_q + fmr_pkg::OUT_CNT_W'(s_valid_q))
               < fmr_pkg::OUT_CNT_W'(fmr_pkg::OUT_DEPTH);
  assign issue      = active_q && space;
  assign is_payload = (job_q.kind == fmr_pkg::KIND_PAYLOAD);
  assign rd_last    = ((ptr_q + fmr_pkg::CNT_W'(1)) == job_q.count);
  assign issue_done = issue && (!is_payload || rd_last);
  assign job_pop_o  = !active_q && job_valid_i;
  assign busy_o     = active_q && is_payload;
  assign out_pop    = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (st_wr_i.we) begin
      mem[st_wr_i.addr[AW-1:0]] <= st_wr_i.data;
    end
    if (issue && is_payload) begin
      rd_data_q <= mem[ptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      ptr_q     <= '0;
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= issue;
      if (job_pop_o) begin
        active_q <= 1'b1;
        ptr_q    <= '0;
      end else begin
        if (issue_done) begin
          active_q <= 1'b0;
        end
        if (issue) begin
          ptr_q <= ptr_q + fmr_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (issue) begin
      s_res_q.kind <= job_q.kind;
      s_res_q.id   <= job_q.id;
      s_res_q.data <= '0;
      s_res_q.idx  <= is_payload ? ptr_q[fmr_pkg::IDX_W-1:0] : '0;
      s_res_q.last <= !is_payload || rd_last;
    end
  end

  always_comb begin
    push_res = s_res_q;
    if (s_res_q.kind == fmr_pkg::KIND_PAYLOAD) begin
      push_res.data = rd_data_q;
    end
  end

  // Output queue; issue only starts when a slot is left for the word in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (s_valid_q) begin
        wr_q <= wr_q + fmr_pkg::OUT_PTR_W'(1);
      end
      if (out_pop) begin
        rd_q <= rd_q + fmr_pkg::OUT_PTR_W'(1);
      end
      cnt_q <= cnt_q + fmr_pkg::OUT_CNT_W'(s_valid_q) - fmr_pkg::OUT_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_q) begin
      fifo_q[wr_q] <= push_res;
    end
  end

  assign empty_o = (cnt_q == '0);
  assign res_o   = fifo_q[rd_q];

endmodule
`default_nettype wire

// ----- sv/framed_message_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_message_receiver_top
// Receiver for DLE/STX framed messages with an additive 8-bit checksum.
// ----------------------------------------------------------------------------
// Usage: words go in through push/full. cmd_i = 0 carries a received byte,
// cmd_i = 1 releases a held frame. Results come out through empty/pop, the
// oldest on the result ports while empty is low. Registers are to be written
// with cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle; the block
// itself does not enforce this. Bytes are taken one per cycle while full is
// low. A good frame's payload is read from the payload store one byte per
// cycle, so a frame with N payload bytes gives N results on consecutive
// cycles when the receiver pops every cycle; the first result passes through
// the job queue, the emitter's job register, its read stage and the output queue.
// While such a stream is still being read out of the store, full stays high.
// Error and empty-frame results are each a single result word.
// A good frame is held until a release.
// A stalled receiver fills the four-word output queue and then the two-entry
// job queue, after which full rises. Reset returns the parser to the start,
// clears the held flag and both queues and loads the register defaults; the
// payload store needs no clearing pass.
// ----------------------------------------------------------------------------
module framed_message_receiver_top #(
  parameter int unsigned PAYLOAD_DEPTH = fmr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          cmd_i,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [1:0]                         kind_o,
  output logic [7:0]                         message_id_o,
  output logic [7:0]                         payload_byte_o,
  output logic [fmr_pkg::IDX_W-1:0]          byte_index_o,
  output logic                               last_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fmr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fmr_pkg::CFG_W-1:0]     cfg_data_i
);

  logic               accept;
  logic               job_push, jq_valid, jq_full, jq_stream, job_pop, back_busy;
  fmr_pkg::job_t      job_in, job_out;
  fmr_pkg::store_wr_t st_wr;
  fmr_pkg::result_t   res;

  // The store must not be rewritten while a payload stream still reads it.
  assign full   = jq_full || jq_stream || back_busy;
  assign accept = push && !full;

  fmr_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .rx_byte_i  (rx_byte_i),
    .job_o      (job_in),
    .job_push_o (job_push),
    .st_wr_o    (st_wr)
  );

  fmr_jobq u_jobq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_push),
    .job_i        (job_in),
    .pop_i        (job_pop),
    .valid_o      (jq_valid),
    .job_o        (job_out),
    .full_o       (jq_full),
    .has_stream_o (jq_stream)
  );

  fmr_back #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_wr_i     (st_wr),
    .job_valid_i (jq_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .busy_o      (back_busy),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign kind_o         = res.kind;
  assign message_id_o   = res.id;
  assign payload_byte_o = res.data;
  assign byte_index_o   = res.idx;
  assign last_o         = res.last;

  a_no_store_write_in_stream: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (jq_stream || back_busy) |-> !st_wr.we
  ) else $error("payload store written while a stream reads it");

  a_no_job_into_full_queue: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !jq_full
  ) else $error("job pushed into a full queue");

  a_single_word_results: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!empty && res.kind != fmr_pkg::KIND_PAYLOAD) |->
      (last_o && byte_index_o == '0 && payload_byte_o == '0)
  ) else $error("error or empty-frame result malformed");

  a_stream_follows_job: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    job_pop |=> !job_pop
  ) else $error("emitter took two jobs in a row");

endmodule
`default_nettype wire
